// ===== rtl/core/fla_pkg.sv =====
// Shared types, sizes and codes for the free-list block allocator.
package fla_pkg;

  // Pool size and derived widths
  localparam int unsigned POOL_CAPACITY = 1024;
  localparam int unsigned BLK_W         = $clog2(POOL_CAPACITY);
  localparam int unsigned CNT_W         = $clog2(POOL_CAPACITY + 1);
  localparam int unsigned REG_W         = 11;
  localparam int unsigned SZ_W          = (REG_W > CNT_W) ? REG_W : CNT_W;
  localparam int unsigned DEFAULT_INIT  = 256;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATER_SIZE = 2'd1;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Request kinds on the input channel
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Classified operations
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_NULL  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ALLOC   = 3'd0;
  localparam logic [2:0] ST_FREED   = 3'd1;
  localparam logic [2:0] ST_NULL    = 3'd2;
  localparam logic [2:0] ST_OOM     = 3'd3;
  localparam logic [2:0] ST_BADFREE = 3'd4;

  typedef struct packed {
    logic             kind;
    logic [BLK_W-1:0] block;
    logic             is_null;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0] granted_block;
    logic [2:0]       status;
    logic [CNT_W-1:0] free_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [BLK_W-1:0] block;
  } cmd_t;

  typedef struct packed {
    logic [REG_W-1:0] first_size;
    logic [REG_W-1:0] later_size;
  } cfg_t;

  // Link memory entry; written is clear until a free stores a link there
  typedef struct packed {
    logic             written;
    logic [BLK_W-1:0] link;
  } link_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] free_blocks;
  } stat_t;

endpackage

// ===== rtl/core/fla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/fla_front.sv =====
// Front end: accepts requests, classifies them and queues commands for the back end.
module fla_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fla_pkg::in_item_t in_data,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output fla_pkg::cmd_t   cmd
);

  fla_pkg::cmd_t               q_mem_r [fla_pkg::QDEPTH];
  logic [fla_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [fla_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [fla_pkg::QCNT_W-1:0]  count_r, count_nxt;
  fla_pkg::cmd_t               new_cmd;
  logic                        push;
  logic                        pop;

  // Classify the request
  always_comb begin
    new_cmd.block = in_data.block;
    if (in_data.kind == fla_pkg::KIND_ALLOC) begin
      new_cmd.op = fla_pkg::OP_ALLOC;
    end else if (in_data.is_null) begin
      new_cmd.op = fla_pkg::OP_NULL;
    end else begin
      new_cmd.op = fla_pkg::OP_FREE;
    end
  end

  assign in_stall  = (count_r == fla_pkg::QCNT_W'(fla_pkg::QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_mem_r[rd_ptr_r];

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == fla_pkg::QPTR_W'(fla_pkg::QDEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == fla_pkg::QPTR_W'(fla_pkg::QDEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== rtl/core/fla_back.sv =====
// Back end: free-list engine with link memory, pool growth and result register.
module fla_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  fla_pkg::cmd_t      cmd,
  input  fla_pkg::cfg_t      cfg,
  output logic               out_valid,
  input  logic               out_stall,
  output fla_pkg::out_item_t out_data,
  output fla_pkg::stat_t     stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LINK  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  // Engine state; an entry never written by a free links to the block below it
  logic [1:0]                  state_r, state_nxt;
  logic [fla_pkg::BLK_W-1:0]   head_r, head_nxt;
  logic [fla_pkg::BLK_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [fla_pkg::CNT_W-1:0]   total_r, total_nxt;
  logic [fla_pkg::CNT_W-1:0]   free_r, free_nxt;
  logic                        grown_r, grown_nxt;
  logic                        out_valid_r, out_valid_nxt;
  fla_pkg::out_item_t          out_r, out_nxt;

  logic                        take;
  fla_pkg::out_item_t          res;
  logic [fla_pkg::SZ_W-1:0]    init_sz;
  logic [fla_pkg::SZ_W-1:0]    grow_sz;
  logic [fla_pkg::SZ_W-1:0]    room;
  logic [fla_pkg::CNT_W-1:0]   grow_n;
  logic                        ram_we;
  logic                        ram_re;
  logic [fla_pkg::BLK_W-1:0]   ram_waddr;
  fla_pkg::link_t              ram_wdata;
  fla_pkg::link_t              ram_rdata;

  // Next links of pushed blocks
  fla_ram #(
    .WIDTH ($bits(fla_pkg::link_t)),
    .DEPTH (fla_pkg::POOL_CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign take      = cmd_valid && (state_r == ST_IDLE) && (!out_valid_r || !out_stall);
  assign cmd_ready = take;

  // Growth size, clamped to the room left in the pool
  always_comb begin
    init_sz = (cfg.first_size == '0) ? fla_pkg::SZ_W'(fla_pkg::DEFAULT_INIT)
                                     : fla_pkg::SZ_W'(cfg.first_size);
    if (grown_r && (cfg.later_size != '0)) begin
      grow_sz = fla_pkg::SZ_W'(cfg.later_size);
    end else begin
      grow_sz = init_sz;
    end
    room   = fla_pkg::SZ_W'(fla_pkg::POOL_CAPACITY) - fla_pkg::SZ_W'(total_r);
    grow_n = (grow_sz > room) ? fla_pkg::CNT_W'(room) : fla_pkg::CNT_W'(grow_sz);
  end

  // Command execution
  always_comb begin
    state_nxt         = state_r;
    head_nxt          = head_r;
    clr_idx_nxt       = clr_idx_r;
    total_nxt         = total_r;
    free_nxt          = free_r;
    grown_nxt         = grown_r;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    ram_waddr         = cmd.block;
    ram_wdata.written = 1'b1;
    ram_wdata.link    = (free_r == '0) ? '0 : head_r;
    res               = '0;

    case (state_r)
      ST_CLEAR: begin
        // mark every link entry unwritten, one per cycle
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == fla_pkg::BLK_W'(fla_pkg::POOL_CAPACITY - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LINK: begin
        // link of the popped head has arrived
        if (ram_rdata.written) begin
          head_nxt = ram_rdata.link;
        end else begin
          head_nxt = head_r - fla_pkg::BLK_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        if (take) begin
          case (cmd.op)
            fla_pkg::OP_ALLOC: begin
              if (free_r != '0) begin
                res.granted_block = head_r;
                res.status        = fla_pkg::ST_ALLOC;
                free_nxt          = free_r - 1'b1;
                if (free_r == fla_pkg::CNT_W'(1)) begin
                  head_nxt = '0;
                end else begin
                  ram_re    = 1'b1;
                  state_nxt = ST_LINK;
                end
              end else if (grow_n != '0) begin
                // grow and hand out the highest new block at once
                res.granted_block = fla_pkg::BLK_W'(total_r + grow_n - 1'b1);
                res.status        = fla_pkg::ST_ALLOC;
                free_nxt          = grow_n - 1'b1;
                total_nxt         = total_r + grow_n;
                grown_nxt         = 1'b1;
                head_nxt          = (grow_n == fla_pkg::CNT_W'(1)) ? '0
                    : fla_pkg::BLK_W'(total_r + grow_n - fla_pkg::CNT_W'(2));
              end else begin
                res.status = fla_pkg::ST_OOM;
              end
            end
            fla_pkg::OP_FREE: begin
              if ((fla_pkg::CNT_W'(cmd.block) >= total_r) || (free_r >= total_r)) begin
                res.status = fla_pkg::ST_BADFREE;
              end else begin
                res.status = fla_pkg::ST_FREED;
                ram_we     = 1'b1;
                head_nxt   = cmd.block;
                free_nxt   = free_r + 1'b1;
              end
            end
            fla_pkg::OP_NULL: begin
              res.status = fla_pkg::ST_NULL;
            end
            default: begin
              res.status = fla_pkg::ST_NULL;
            end
          endcase
        end
      end
    endcase
    res.free_count = free_nxt;
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      head_r      <= '0;
      clr_idx_r   <= '0;
      total_r     <= '0;
      free_r      <= '0;
      grown_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      clr_idx_r   <= clr_idx_nxt;
      total_r     <= total_nxt;
      free_r      <= free_nxt;
      grown_r     <= grown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.total_count = total_r;
  assign stat.free_blocks = free_r;

endmodule

// ===== rtl/core/free_list_block_allocator.sv =====
// A request passes through the command queue into the back end, whose result is registered.
// The back end takes one request per cycle unless its result is stalled, except that an
// allocate from a list of two or more free blocks enters a state that reads the next link.
// A two-entry command queue keeps accepting requests while a result waits.
// Reset (rst_n, synchronous, active low) empties the pool, sets the growth registers
// to 256 and 0 and starts a pass that clears the link memory.
module free_list_block_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fla_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fla_pkg::out_item_t              out_data,
  input  logic                            cfg_wr_en,
  input  logic [fla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fla_pkg::REG_W-1:0]       cfg_wdata
);

  fla_pkg::cfg_t  cfg_r, cfg_nxt;
  fla_pkg::cmd_t  cmd;
  fla_pkg::stat_t stat;
  logic           cmd_valid;
  logic           cmd_ready;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        fla_pkg::REG_FIRST_SIZE: cfg_nxt.first_size = cfg_wdata;
        fla_pkg::REG_LATER_SIZE: cfg_nxt.later_size = cfg_wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_size <= fla_pkg::REG_W'(fla_pkg::DEFAULT_INIT);
      cfg_r.later_size <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fla_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fla_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (stat)
  );

  // Free blocks never outnumber blocks in the pool
  a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    stat.free_blocks <= stat.total_count)
    else $error("free count exceeds pool size");

  // The pool never shrinks
  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> stat.total_count >= $past(stat.total_count))
    else $error("pool size decreased");

  // A granted block lies inside the pool
  a_grant_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == fla_pkg::ST_ALLOC) |->
      fla_pkg::CNT_W'(out_data.granted_block) < stat.total_count)
    else $error("granted block outside pool");

  // Out of memory only when no block is free
  a_oom_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == fla_pkg::ST_OOM) |-> out_data.free_count == '0)
    else $error("out of memory reported with free blocks");

endmodule

// ===== test/tb_free_list_block_allocator.sv =====
// Self-checking testbench for the free-list block allocator.
`timescale 1ns / 1ps

module tb_free_list_block_allocator;

  // Indexes past the register list; writes to them must have no effect
  localparam logic [fla_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [fla_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int FEED_DEPTH = 4;
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fla_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fla_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [fla_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fla_pkg::REG_W-1:0] cfg_wdata = '0;

  free_list_block_allocator uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Allocator state as predicted from accepted requests
  logic [fla_pkg::BLK_W-1:0] link_mem [fla_pkg::POOL_CAPACITY];
  int unsigned pool_head = 0;
  bit list_empty = 1'b1;
  int unsigned pool_total = 0;
  int unsigned free_total = 0;
  bit grown_once = 1'b0;
  int unsigned initial_size = fla_pkg::DEFAULT_INIT;
  int unsigned grow_size = 0;

  fla_pkg::in_item_t request_feed[$];
  fla_pkg::out_item_t predicted_replies[$];
  int blocks_in_use[$];

  int error_count = 0;
  int transfers_in = 0;
  int n_alloc = 0, n_freed = 0, n_null = 0, n_oom = 0, n_rejected = 0;
  int oom_predicted = 0;
  bit idling = 1'b1;
  int hold_trips = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6ms;
    $display("tb_free_list_block_allocator: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Gap length for either side: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!idling || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Predict the reply to one request and update the predicted pool
  task automatic apply_request(input fla_pkg::in_item_t req);
    fla_pkg::out_item_t reply;
    int unsigned n;
    int unsigned i;
    reply = '0;
    if (req.kind == fla_pkg::KIND_ALLOC) begin
      if (list_empty) begin
        // Grow the pool by the current register setting, clamped to capacity
        n = (initial_size != 0) ? initial_size : fla_pkg::DEFAULT_INIT;
        if (grown_once && grow_size != 0) n = grow_size;
        if (n > fla_pkg::POOL_CAPACITY - pool_total) n = fla_pkg::POOL_CAPACITY - pool_total;
        for (i = 0; i < n; i++) begin
          link_mem[pool_total + i] = list_empty ? '0 : fla_pkg::BLK_W'(pool_head);
          pool_head = pool_total + i;
          list_empty = 1'b0;
        end
        pool_total += n;
        free_total += n;
        if (n != 0) grown_once = 1'b1;
      end
      if (list_empty) begin
        reply.status = fla_pkg::ST_OOM;
        oom_predicted++;
      end else begin
        reply.granted_block = fla_pkg::BLK_W'(pool_head);
        blocks_in_use = {blocks_in_use, pool_head};
        pool_head = link_mem[pool_head];
        free_total--;
        list_empty = (free_total == 0);
        if (list_empty) pool_head = 0;
        reply.status = fla_pkg::ST_ALLOC;
      end
    end else if (req.is_null) begin
      reply.status = fla_pkg::ST_NULL;
    end else if (req.block >= pool_total || free_total >= pool_total) begin
      reply.status = fla_pkg::ST_BADFREE;
    end else begin
      link_mem[req.block] = list_empty ? '0 : fla_pkg::BLK_W'(pool_head);
      pool_head = req.block;
      list_empty = 1'b0;
      free_total++;
      reply.status = fla_pkg::ST_FREED;
    end
    reply.free_count = fla_pkg::CNT_W'(free_total);
    predicted_replies = {predicted_replies, reply};
  endtask

  // Request driver: predicts on each transfer, then offers the next item
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(in_data);
        transfers_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_feed.size() > 0) begin
          in_data <= request_feed.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall: random runs, plus a long hold on request
  int stall_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (hold_trips != hold_seen) begin
      hold_seen = hold_trips;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    fla_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want = predicted_replies.pop_front();
        if (out_data.granted_block !== want.granted_block)
          report_mismatch($sformatf("granted_block %0d, want %0d",
                                    out_data.granted_block, want.granted_block));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_data.status, want.status));
        if (out_data.free_count !== want.free_count)
          report_mismatch($sformatf("free_count %0d, want %0d",
                                    out_data.free_count, want.free_count));
      end
      case (out_data.status)
        fla_pkg::ST_ALLOC:   n_alloc++;
        fla_pkg::ST_FREED:   n_freed++;
        fla_pkg::ST_NULL:    n_null++;
        fla_pkg::ST_OOM:     n_oom++;
        fla_pkg::ST_BADFREE: n_rejected++;
        default:    ;
      endcase
    end
  end

  task automatic write_reg(input logic [fla_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= fla_pkg::REG_W'(value);
    if (idx == fla_pkg::REG_FIRST_SIZE) initial_size = value;
    else if (idx == fla_pkg::REG_LATER_SIZE) grow_size = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic fla_pkg::in_item_t make_req(input logic kind, input int unsigned blk,
                                                 input logic is_null);
    fla_pkg::in_item_t it;
    it.kind = kind;
    it.block = fla_pkg::BLK_W'(blk);
    it.is_null = is_null;
    return it;
  endfunction

  task automatic queue_item(input fla_pkg::in_item_t it);
    while (request_feed.size() >= FEED_DEPTH) @(negedge clk);
    request_feed = {request_feed, it};
  endtask

  // Random request: allocates carry junk fields; frees mostly return held blocks
  function automatic fla_pkg::in_item_t random_request(input int alloc_pct);
    fla_pkg::in_item_t it;
    int r;
    int k;
    it.kind = fla_pkg::KIND_ALLOC;
    it.block = fla_pkg::BLK_W'($urandom);
    it.is_null = 1'($urandom_range(1));
    if ($urandom_range(99) >= alloc_pct) begin
      it.kind = fla_pkg::KIND_FREE;
      it.is_null = 1'b0;
      r = $urandom_range(99);
      if (r < 80 && blocks_in_use.size() > 0) begin
        k = $urandom_range(blocks_in_use.size() - 1);
        it.block = fla_pkg::BLK_W'(blocks_in_use[k]);
        blocks_in_use.delete(k);
      end else if (r < 88) begin
        it.is_null = 1'b1;
      end else if (r >= 94 && pool_total > 0) begin
        // block inside the pool, likely already free
        it.block = fla_pkg::BLK_W'($urandom_range(pool_total - 1));
      end
    end
    return it;
  endfunction

  task automatic run_phase(input int n, input int alloc_pct);
    fla_pkg::in_item_t it;
    int issued;
    issued = 0;
    while (issued < n) begin
      it = random_request(alloc_pct);
      queue_item(it);
      if (!(it.kind == fla_pkg::KIND_FREE && it.is_null)) issued++;
    end
  endtask

  task automatic wait_idle();
    while (request_feed.size() != 0 || in_valid || predicted_replies.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ignored indexes, one-block growths, null, alien and double frees
    write_reg(REG_SPARE_2, 2047);
    write_reg(REG_SPARE_3, 5);
    write_reg(fla_pkg::REG_FIRST_SIZE, 1);
    write_reg(fla_pkg::REG_LATER_SIZE, 0);
    queue_item(make_req(fla_pkg::KIND_FREE, 1023, 1'b1));
    queue_item(make_req(fla_pkg::KIND_FREE, 0, 1'b0));
    queue_item(make_req(fla_pkg::KIND_ALLOC, 1023, 1'b1));
    queue_item(make_req(fla_pkg::KIND_ALLOC, 341, 1'b0));
    queue_item(make_req(fla_pkg::KIND_FREE, 1, 1'b0));
    queue_item(make_req(fla_pkg::KIND_FREE, 1, 1'b0));
    queue_item(make_req(fla_pkg::KIND_FREE, 0, 1'b0));
    queue_item(make_req(fla_pkg::KIND_ALLOC, 0, 1'b1));
    queue_item(make_req(fla_pkg::KIND_ALLOC, 682, 1'b0));
    queue_item(make_req(fla_pkg::KIND_FREE, 1023, 1'b0));
    queue_item(make_req(fla_pkg::KIND_FREE, 2, 1'b0));
    queue_item(make_req(fla_pkg::KIND_FREE, 0, 1'b0));
    queue_item(make_req(fla_pkg::KIND_FREE, 1, 1'b0));
    queue_item(make_req(fla_pkg::KIND_FREE, 1, 1'b0));
    queue_item(make_req(fla_pkg::KIND_FREE, 0, 1'b1));
    queue_item(make_req(fla_pkg::KIND_ALLOC, 1023, 1'b0));
    queue_item(make_req(fla_pkg::KIND_ALLOC, 0, 1'b1));
    queue_item(make_req(fla_pkg::KIND_ALLOC, 512, 1'b1));
    queue_item(make_req(fla_pkg::KIND_ALLOC, 0, 1'b0));
    wait_idle();

    // Small later growths, with a long result hold at the start
    write_reg(fla_pkg::REG_FIRST_SIZE, 1024);
    write_reg(fla_pkg::REG_LATER_SIZE, 7);
    hold_trips++;
    run_phase(200, 55);
    wait_idle();

    // Zero in both registers: growths of the default size; sender pauses midway
    write_reg(fla_pkg::REG_FIRST_SIZE, 0);
    write_reg(fla_pkg::REG_LATER_SIZE, 0);
    run_phase(100, 55);
    wait_idle();
    run_phase(100, 55);
    wait_idle();

    // Largest growth, clamped to what is left of the pool; no idling
    idling = 1'b0;
    write_reg(fla_pkg::REG_FIRST_SIZE, 3);
    write_reg(fla_pkg::REG_LATER_SIZE, 1024);
    run_phase(200, 95);
    wait_idle();
    idling = 1'b1;

    // Exhaust the pool, then mix frees with out-of-memory allocates
    write_reg(fla_pkg::REG_FIRST_SIZE, 1024);
    write_reg(fla_pkg::REG_LATER_SIZE, 1);
    hold_trips++;
    while (oom_predicted < 4) run_phase(1, 97);
    run_phase(40, 50);
    wait_idle();

    repeat (10) @(posedge clk);
    $display("covered %0d transfers: %0d allocated, %0d freed, %0d null, %0d out of memory,",
             transfers_in, n_alloc, n_freed, n_null, n_oom);
    $display("%0d rejected frees; pool grew to %0d blocks under five register settings",
             n_rejected, pool_total);
    if (error_count == 0)
      $display("tb_free_list_block_allocator: done, clean");
    else
      $display("tb_free_list_block_allocator: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fla_pkg.sv
rtl/core/fla_ram.sv
rtl/core/fla_front.sv
rtl/core/fla_back.sv
rtl/core/free_list_block_allocator.sv
test/tb_free_list_block_allocator.sv
